[rtl/core/sfd_pkg.sv]
package sfd_pkg;

    localparam logic [7:0]  PREFIX_HI  = 8'd79;
    localparam logic [7:0]  PREFIX_LO  = 8'd213;
    localparam logic [7:0]  EMG_OFFSET = 8'd200;
    localparam logic [7:0]  MIN_LEN    = 8'd2;
    localparam logic [12:0] BATT_BASE  = 13'd2000;

    localparam int HDR_BYTES = 13;
    localparam int HDR_IW    = $clog2(HDR_BYTES);
    localparam int TDATA_W   = 144;
    localparam int PADDR_W   = 4;

    localparam logic [1:0] REG_BATT  = 2'd0;
    localparam logic [1:0] REG_STEPS = 2'd1;
    localparam logic [1:0] REG_ACCEL = 2'd2;

    typedef enum logic [2:0] {
        PH_HUNT0,
        PH_HUNT1,
        PH_RSSI,
        PH_LEN,
        PH_BODY
    } t_phase;

    typedef enum logic [1:0] {
        ST_PARAM = 2'd0,
        ST_EMG   = 2'd1,
        ST_ERR   = 2'd2
    } t_status;

    typedef logic [HDR_BYTES-1:0][7:0] t_hdr;

    typedef struct packed {
        logic err;
        t_hdr hdr;
    } t_frame_ev;

    typedef struct packed {
        t_status     status;
        logic [7:0]  rssi;
        logic [7:0]  packet_number;
        logic [31:0] unit_code;
        logic [3:0]  unit_slot;
        logic [7:0]  point_count;
        logic [12:0] battery_mv;
        logic        battery_valid;
        logic [7:0]  param_code;
        logic [23:0] param_word;
        logic [15:0] emg_amplitude;
        logic [15:0] spectrum_scale;
    } t_result;

    function automatic logic [12:0] batt_mv(input logic [7:0] b);
        return BATT_BASE + {2'b00, b, 3'b000} + {4'b0000, b, 1'b0};
    endfunction

endpackage

[rtl/core/sensor_frame_deframer_core.sv]
// Byte-stream deframer for a sensor base-station link. One byte enters per
// s_ beat, and a byte is taken in every cycle while the result side keeps up.
// The block hunts for the prefix 79,213, captures the RSSI byte and a
// length-prefixed frame, and checks the modulo-256 checksum in the last
// frame byte. At the end of each frame one result beat leaves on m_: a
// decoded parameter or EMG header (m_tuser 0 or 1) or a checksum or length error
// (m_tuser 2, only rssi and packet number set). The result passes through
// the frame event register and then the output register, where the unit-id
// lookup and the table update are done against all UNIT_SLOTS entries in
// parallel. The unit table is cleared at reset. Registers on the APB port:
// battery parameter code at 0x0, step code at 0x4, accelerometer code at 0x8;
// write them only while no frame is in progress.
module sensor_frame_deframer_core #(
    parameter int UNIT_SLOTS = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [7:0]                  s_tdata,   // [7:0] byte_in
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // [7:0] rssi, [15:8] packet_number, [47:16] unit_code, [51:48] unit_slot,
    // [59:52] point_count, [72:60] battery_mv, [73] battery_valid,
    // [81:74] param_code, [105:82] param_word, [121:106] emg_amplitude,
    // [137:122] spectrum_scale, [143:138] zero
    output logic [sfd_pkg::TDATA_W-1:0] m_tdata,
    output logic [1:0]                  m_tuser,   // [1:0] status
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [sfd_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    logic [7:0] r_batt_code;
    logic [7:0] r_steps_code;
    logic [7:0] r_accel_code;
    logic       cfg_wr;

    logic               ev_valid;
    logic               ev_ready;
    sfd_pkg::t_frame_ev ev;
    logic [31:0]        unit_id;
    logic [3:0]         unit_slot;
    sfd_pkg::t_result   res;
    logic               r_out_valid;
    sfd_pkg::t_result   r_res;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_batt_code  <= 8'd0;
            r_steps_code <= 8'd1;
            r_accel_code <= 8'd2;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                sfd_pkg::REG_BATT:  r_batt_code  <= pwdata[7:0];
                sfd_pkg::REG_STEPS: r_steps_code <= pwdata[7:0];
                sfd_pkg::REG_ACCEL: r_accel_code <= pwdata[7:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            sfd_pkg::REG_BATT:  prdata = {24'd0, r_batt_code};
            sfd_pkg::REG_STEPS: prdata = {24'd0, r_steps_code};
            sfd_pkg::REG_ACCEL: prdata = {24'd0, r_accel_code};
            default:            prdata = '0;
        endcase
    end

    sfd_parser u_parser (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s_tvalid),
        .o_ready    (s_tready),
        .i_byte     (s_tdata),
        .o_ev_valid (ev_valid),
        .i_ev_ready (ev_ready),
        .o_ev       (ev)
    );

    sfd_decode u_decode (
        .i_ev        (ev),
        .i_slot      (unit_slot),
        .i_batt_code (r_batt_code),
        .o_id        (unit_id),
        .o_res       (res)
    );

    sfd_unit_table #(
        .UNIT_SLOTS (UNIT_SLOTS)
    ) u_table (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_id     (unit_id),
        .i_commit (ev_valid && ev_ready && !ev.err),
        .o_slot   (unit_slot)
    );

    assign ev_ready = !r_out_valid || m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ev_ready) begin
            r_out_valid <= ev_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ev_valid && ev_ready) r_res <= res;
    end

    assign m_tvalid = r_out_valid;
    assign m_tuser  = r_res.status;
    assign m_tdata  = {6'd0, r_res.spectrum_scale, r_res.emg_amplitude, r_res.param_word,
                       r_res.param_code, r_res.battery_valid, r_res.battery_mv,
                       r_res.point_count, r_res.unit_slot, r_res.unit_code,
                       r_res.packet_number, r_res.rssi};

endmodule

[rtl/core/sfd_parser.sv]
module sfd_parser (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [7:0]         i_byte,
    output logic               o_ev_valid,
    input  logic               i_ev_ready,
    output sfd_pkg::t_frame_ev o_ev
);

    sfd_pkg::t_phase    r_phase, n_phase;
    logic [7:0]         r_idx, n_idx;
    logic [7:0]         r_len, n_len;
    logic [7:0]         r_sum, n_sum;
    sfd_pkg::t_hdr      r_hdr, n_hdr;
    logic               r_ev_valid;
    sfd_pkg::t_frame_ev r_ev;

    logic accept;
    logic last;
    logic fire;
    logic fire_err;

    assign o_ready    = !r_ev_valid || i_ev_ready;
    assign accept     = i_valid && o_ready;
    assign last       = ({1'b0, r_idx} + 9'd1) >= {1'b0, r_len};
    assign o_ev_valid = r_ev_valid;
    assign o_ev       = r_ev;

    always_comb begin
        n_phase = r_phase;
        if (accept) begin
            unique case (r_phase)
                sfd_pkg::PH_HUNT0: begin
                    if (i_byte == sfd_pkg::PREFIX_HI) n_phase = sfd_pkg::PH_HUNT1;
                end
                sfd_pkg::PH_HUNT1: begin
                    if (i_byte == sfd_pkg::PREFIX_LO) n_phase = sfd_pkg::PH_RSSI;
                    else if (i_byte != sfd_pkg::PREFIX_HI) n_phase = sfd_pkg::PH_HUNT0;
                end
                sfd_pkg::PH_RSSI: n_phase = sfd_pkg::PH_LEN;
                sfd_pkg::PH_LEN: begin
                    if (i_byte < sfd_pkg::MIN_LEN) n_phase = sfd_pkg::PH_HUNT0;
                    else n_phase = sfd_pkg::PH_BODY;
                end
                sfd_pkg::PH_BODY: begin
                    if (last) n_phase = sfd_pkg::PH_HUNT0;
                end
                default: n_phase = sfd_pkg::PH_HUNT0;
            endcase
        end
    end

    always_comb begin
        n_idx    = r_idx;
        n_len    = r_len;
        n_sum    = r_sum;
        n_hdr    = r_hdr;
        fire     = 1'b0;
        fire_err = 1'b0;
        if (accept) begin
            case (r_phase)
                sfd_pkg::PH_RSSI: begin
                    n_hdr    = '0;
                    n_hdr[0] = i_byte;
                end
                sfd_pkg::PH_LEN: begin
                    n_len = i_byte;
                    n_sum = i_byte;
                    n_idx = 8'd1;
                    if (i_byte < sfd_pkg::MIN_LEN) begin
                        fire     = 1'b1;
                        fire_err = 1'b1;
                    end
                end
                sfd_pkg::PH_BODY: begin
                    if (r_idx < 8'(sfd_pkg::HDR_BYTES)) begin
                        n_hdr[r_idx[sfd_pkg::HDR_IW-1:0]] = i_byte;
                    end
                    if (last) begin
                        fire     = 1'b1;
                        fire_err = (i_byte != r_sum);
                    end else begin
                        n_sum = r_sum + i_byte;
                        n_idx = r_idx + 8'd1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= sfd_pkg::PH_HUNT0;
            r_idx      <= '0;
            r_len      <= '0;
            r_sum      <= '0;
            r_ev_valid <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_idx   <= n_idx;
            r_len   <= n_len;
            r_sum   <= n_sum;
            if (o_ready) r_ev_valid <= fire;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hdr <= n_hdr;
        if (fire) begin
            r_ev.err <= fire_err;
            r_ev.hdr <= n_hdr;
        end
    end

endmodule

[rtl/core/sfd_unit_table.sv]
module sfd_unit_table #(
    parameter int UNIT_SLOTS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [31:0] i_id,
    input  logic        i_commit,
    output logic [3:0]  o_slot
);

    localparam int SW = (UNIT_SLOTS > 1) ? $clog2(UNIT_SLOTS) : 1;

    logic [31:0]   r_table [UNIT_SLOTS];
    logic          hit;
    logic [SW-1:0] hit_slot;
    logic          empty;
    logic [SW-1:0] empty_slot;

    always_comb begin
        hit      = 1'b0;
        hit_slot = '0;
        for (int n = 0; n < UNIT_SLOTS; n++) begin
            if (r_table[n] == i_id) begin
                hit      = 1'b1;
                hit_slot = SW'(n);
            end
        end
    end

    always_comb begin
        empty      = 1'b0;
        empty_slot = '0;
        for (int n = UNIT_SLOTS - 1; n >= 0; n--) begin
            if (r_table[n] == 32'd0) begin
                empty      = 1'b1;
                empty_slot = SW'(n);
            end
        end
    end

    always_comb begin
        if (hit) o_slot = 4'(hit_slot);
        else if (empty) o_slot = 4'(empty_slot);
        else o_slot = 4'(UNIT_SLOTS);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int n = 0; n < UNIT_SLOTS; n++) r_table[n] <= '0;
        end else if (i_commit && !hit && empty) begin
            r_table[empty_slot] <= i_id;
        end
    end

endmodule

[rtl/core/sfd_decode.sv]
module sfd_decode (
    input  sfd_pkg::t_frame_ev i_ev,
    input  logic [3:0]         i_slot,
    input  logic [7:0]         i_batt_code,
    output logic [31:0]        o_id,
    output sfd_pkg::t_result   o_res
);

    sfd_pkg::t_hdr h;
    logic          is_emg;

    assign h      = i_ev.hdr;
    assign o_id   = {h[2], h[3], h[4], h[5]};
    assign is_emg = h[6] > sfd_pkg::EMG_OFFSET;

    always_comb begin
        o_res               = '0;
        o_res.rssi          = h[0];
        o_res.packet_number = h[1];
        if (i_ev.err) begin
            o_res.status = sfd_pkg::ST_ERR;
        end else begin
            o_res.unit_code = o_id;
            o_res.unit_slot = i_slot;
            if (is_emg) begin
                o_res.status         = sfd_pkg::ST_EMG;
                o_res.point_count    = h[6] - sfd_pkg::EMG_OFFSET;
                o_res.battery_mv     = sfd_pkg::batt_mv(h[7]);
                o_res.battery_valid  = 1'b1;
                o_res.emg_amplitude  = {h[9], h[10]};
                o_res.spectrum_scale = {h[11], h[12]};
            end else begin
                o_res.status      = sfd_pkg::ST_PARAM;
                o_res.point_count = h[6];
                o_res.param_code  = h[7];
                o_res.param_word  = {h[8], h[9], h[10]};
                if (h[7] == i_batt_code) begin
                    o_res.battery_mv    = sfd_pkg::batt_mv(h[8]);
                    o_res.battery_valid = 1'b1;
                end
            end
        end
    end

endmodule

[rtl/core/sfd_checker.sv]
module sfd_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        m_tvalid,
    input logic                        m_tready,
    input logic [sfd_pkg::TDATA_W-1:0] m_tdata,
    input logic [1:0]                  m_tuser
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result beat changed");

    a_err_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tuser == sfd_pkg::ST_ERR |-> m_tdata[sfd_pkg::TDATA_W-1:16] == '0)
        else $error("error beat carries decoded fields");

    a_param_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tuser == sfd_pkg::ST_PARAM |-> m_tdata[137:106] == '0)
        else $error("parameter beat carries EMG fields");

    a_emg_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tuser == sfd_pkg::ST_EMG |-> m_tdata[73] && m_tdata[105:74] == '0)
        else $error("EMG beat has wrong battery or parameter fields");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind sensor_frame_deframer_core sfd_checker u_sfd_checker (.*);
